FILE: design/fsg_pkg.sv
// ----------------------------------------------------------------------------
// fsg_pkg
// Shared types, constants and helpers for the falling-sand grid engine.
// ----------------------------------------------------------------------------
package fsg_pkg;

  localparam int unsigned GRID_W_DEF = 64;
  localparam int unsigned GRID_H_DEF = 64;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_CHANGE_AFTER = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_SIZE = 8'd1;

  localparam logic [7:0] CHANGE_AFTER_RST = 8'd150;
  localparam logic [3:0] PALETTE_SIZE_RST = 4'd7;

  typedef enum logic [1:0] {
    OP_PLACE = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PL_CHK,
    ST_RD_CHK,
    ST_SW_SRC,
    ST_SW_DN,
    ST_SW_DR,
    ST_SW_DL,
    ST_SW_CLR,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic       occ;
    logic [2:0] color;
  } cell_t;

  typedef struct packed {
    logic       accepted;
    logic       occupied;
    logic [2:0] grain_color;
  } res_t;

  // (color + 1) mod clamp(psize, 1, 8); value stays below 9, so eight
  // conditional subtracts are enough
  function automatic logic [2:0] color_next(input logic [2:0] color,
                                            input logic [3:0] psize);
    logic [3:0] p;
    logic [3:0] v;
    p = psize;
    if (p == 4'd0) p = 4'd1;
    if (p > 4'd8) p = 4'd8;
    v = {1'b0, color} + 4'd1;
    for (int i = 0; i < 8; i++) begin
      if (v >= p) v = v - p;
    end
    return v[2:0];
  endfunction

endpackage

FILE: design/fsg_ram.sv
// ----------------------------------------------------------------------------
// fsg_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fsg_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/fsg_palette.sv
// ----------------------------------------------------------------------------
// fsg_palette
// Configuration registers, placement counter and current color index.
// ----------------------------------------------------------------------------
module fsg_palette (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fsg_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fsg_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            commit_i,
  output logic [2:0]                      color_o
);

  logic [7:0] change_after_q;
  logic [3:0] palette_size_q;
  logic [7:0] count_q, count_d;
  logic [2:0] color_q, color_d;
  logic [7:0] count_inc;

  assign count_inc = count_q + 8'd1;

  always_comb begin
    count_d = count_q;
    color_d = color_q;
    if (commit_i) begin
      if (count_inc >= change_after_q) begin
        count_d = 8'd0;
        color_d = fsg_pkg::color_next(color_q, palette_size_q);
      end else begin
        count_d = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      change_after_q <= fsg_pkg::CHANGE_AFTER_RST;
      palette_size_q <= fsg_pkg::PALETTE_SIZE_RST;
      count_q        <= 8'd0;
      color_q        <= 3'd0;
    end else begin
      if (cfg_we_i && cfg_index_i == fsg_pkg::REG_CHANGE_AFTER) begin
        change_after_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_index_i == fsg_pkg::REG_PALETTE_SIZE) begin
        palette_size_q <= cfg_data_i[3:0];
      end
      count_q <= count_d;
      color_q <= color_d;
    end
  end

  assign color_o = color_q;

endmodule

FILE: design/fsg_ctrl.sv
// ----------------------------------------------------------------------------
// fsg_ctrl
// Sequencer: clearing pass, place read-modify-write, cell read and gravity
// sweep against the cell RAM.
// ----------------------------------------------------------------------------
module fsg_ctrl #(
  parameter int unsigned GRID_W = fsg_pkg::GRID_W_DEF,
  parameter int unsigned GRID_H = fsg_pkg::GRID_H_DEF,
  localparam int unsigned CW = $clog2(GRID_W),
  localparam int unsigned RW = $clog2(GRID_H),
  localparam int unsigned AW = CW + RW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_accept_i,
  input  logic [1:0]           opcode_i,
  input  logic [5:0]           col_i,
  input  logic [5:0]           row_i,
  output logic                 busy_o,
  input  logic [2:0]           color_i,
  output logic                 commit_o,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output fsg_pkg::res_t        res_o,
  output logic                 ram_we_o,
  output logic [AW-1:0]        ram_waddr_o,
  output logic [3:0]           ram_wdata_o,
  output logic                 ram_re_o,
  output logic [AW-1:0]        ram_raddr_o,
  input  logic [3:0]           ram_rdata_i
);

  localparam logic [CW-1:0] COL_LAST = CW'(GRID_W - 1);
  localparam logic [RW-1:0] ROW_TOP  = RW'(GRID_H - 2);

  fsg_pkg::state_e state_q, state_d;
  fsg_pkg::cell_t  rd_cell, src_q;
  fsg_pkg::res_t   res_q;

  logic [AW-1:0] clr_q;
  logic [CW-1:0] col_q, col_p1, col_m1, nxt_col, in_col;
  logic [RW-1:0] row_q, row_p1, nxt_row, in_row;
  logic          inside_q, in_inside;
  logic          last_cell, has_right, has_left;
  logic          adv;
  logic [8:0]    col_ext, row_ext;
  fsg_pkg::opcode_e in_op;

  assign in_op     = fsg_pkg::opcode_e'(opcode_i);
  assign col_ext   = 9'(col_i);
  assign row_ext   = 9'(row_i);
  assign in_inside = (col_ext < 9'(GRID_W)) && (row_ext < 9'(GRID_H));
  assign in_col    = col_ext[CW-1:0];
  assign in_row    = row_ext[RW-1:0];

  assign rd_cell   = fsg_pkg::cell_t'(ram_rdata_i);
  assign col_p1    = col_q + 1'b1;
  assign col_m1    = col_q - 1'b1;
  assign row_p1    = row_q + 1'b1;
  assign last_cell = (row_q == '0) && (col_q == COL_LAST);
  assign has_right = (col_q != COL_LAST);
  assign has_left  = (col_q != '0);
  assign nxt_col   = (row_q == '0) ? col_p1 : col_q;
  assign nxt_row   = (row_q == '0) ? ROW_TOP : row_q - 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fsg_pkg::ST_CLEAR: begin
        if (&clr_q) state_d = fsg_pkg::ST_IDLE;
      end
      fsg_pkg::ST_IDLE: begin
        if (in_accept_i) begin
          unique case (in_op)
            fsg_pkg::OP_PLACE: state_d = fsg_pkg::ST_PL_CHK;
            fsg_pkg::OP_STEP:  state_d = fsg_pkg::ST_SW_SRC;
            fsg_pkg::OP_READ:  state_d = fsg_pkg::ST_RD_CHK;
            default:           state_d = fsg_pkg::ST_RESP;
          endcase
        end
      end
      fsg_pkg::ST_PL_CHK, fsg_pkg::ST_RD_CHK: state_d = fsg_pkg::ST_RESP;
      fsg_pkg::ST_SW_SRC: begin
        if (rd_cell.occ)    state_d = fsg_pkg::ST_SW_DN;
        else if (last_cell) state_d = fsg_pkg::ST_RESP;
      end
      fsg_pkg::ST_SW_DN: begin
        if (!rd_cell.occ)   state_d = fsg_pkg::ST_SW_CLR;
        else if (has_right) state_d = fsg_pkg::ST_SW_DR;
        else if (has_left)  state_d = fsg_pkg::ST_SW_DL;
        else if (last_cell) state_d = fsg_pkg::ST_RESP;
        else                state_d = fsg_pkg::ST_SW_SRC;
      end
      fsg_pkg::ST_SW_DR: begin
        if (!rd_cell.occ)   state_d = fsg_pkg::ST_SW_CLR;
        else if (has_left)  state_d = fsg_pkg::ST_SW_DL;
        else if (last_cell) state_d = fsg_pkg::ST_RESP;
        else                state_d = fsg_pkg::ST_SW_SRC;
      end
      fsg_pkg::ST_SW_DL: begin
        if (!rd_cell.occ)   state_d = fsg_pkg::ST_SW_CLR;
        else if (last_cell) state_d = fsg_pkg::ST_RESP;
        else                state_d = fsg_pkg::ST_SW_SRC;
      end
      fsg_pkg::ST_SW_CLR: begin
        state_d = last_cell ? fsg_pkg::ST_RESP : fsg_pkg::ST_SW_SRC;
      end
      fsg_pkg::ST_RESP: begin
        if (res_ready_i) state_d = fsg_pkg::ST_IDLE;
      end
      default: state_d = fsg_pkg::ST_IDLE;
    endcase
  end

  // RAM accesses and strobes; adv issues the read of the next sweep cell
  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = '0;
    ram_wdata_o = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = '0;
    commit_o    = 1'b0;
    adv         = 1'b0;
    unique case (state_q)
      fsg_pkg::ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
      end
      fsg_pkg::ST_IDLE: begin
        if (in_accept_i) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = (in_op == fsg_pkg::OP_STEP) ? {{CW{1'b0}}, ROW_TOP} : {in_col, in_row};
        end
      end
      fsg_pkg::ST_PL_CHK: begin
        if (inside_q && !rd_cell.occ) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = {col_q, row_q};
          ram_wdata_o = {1'b1, color_i};
          commit_o    = 1'b1;
        end
      end
      fsg_pkg::ST_RD_CHK: ;
      fsg_pkg::ST_SW_SRC: begin
        if (rd_cell.occ) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = {col_q, row_p1};
        end else begin
          adv = !last_cell;
        end
      end
      fsg_pkg::ST_SW_DN: begin
        if (!rd_cell.occ) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = {col_q, row_p1};
          ram_wdata_o = src_q;
        end else if (has_right) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = {col_p1, row_p1};
        end else if (has_left) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = {col_m1, row_p1};
        end else begin
          adv = !last_cell;
        end
      end
      fsg_pkg::ST_SW_DR: begin
        if (!rd_cell.occ) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = {col_p1, row_p1};
          ram_wdata_o = src_q;
        end else if (has_left) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = {col_m1, row_p1};
        end else begin
          adv = !last_cell;
        end
      end
      fsg_pkg::ST_SW_DL: begin
        if (!rd_cell.occ) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = {col_m1, row_p1};
          ram_wdata_o = src_q;
        end else begin
          adv = !last_cell;
        end
      end
      fsg_pkg::ST_SW_CLR: begin
        // vacate the source; next source read never hits this address
        ram_we_o    = 1'b1;
        ram_waddr_o = {col_q, row_q};
        adv         = !last_cell;
      end
      fsg_pkg::ST_RESP: ;
      default: ;
    endcase
    if (adv) begin
      ram_re_o    = 1'b1;
      ram_raddr_o = {nxt_col, nxt_row};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fsg_pkg::ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == fsg_pkg::ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == fsg_pkg::ST_IDLE && in_accept_i) begin
      inside_q <= in_inside;
      res_q    <= '0;
      if (in_op == fsg_pkg::OP_STEP) begin
        col_q <= '0;
        row_q <= ROW_TOP;
      end else begin
        col_q <= in_col;
        row_q <= in_row;
      end
    end
    if (adv) begin
      col_q <= nxt_col;
      row_q <= nxt_row;
    end
    if (state_q == fsg_pkg::ST_SW_SRC && rd_cell.occ) begin
      src_q <= rd_cell;
    end
    if (state_q == fsg_pkg::ST_PL_CHK) begin
      res_q.accepted <= inside_q && !rd_cell.occ;
    end
    if (state_q == fsg_pkg::ST_RD_CHK && inside_q && rd_cell.occ) begin
      res_q.occupied    <= 1'b1;
      res_q.grain_color <= rd_cell.color;
    end
  end

  assign busy_o      = (state_q != fsg_pkg::ST_IDLE);
  assign res_valid_o = (state_q == fsg_pkg::ST_RESP);
  assign res_o       = res_q;

endmodule

FILE: design/falling_sand_grid_engine_core.sv
// ----------------------------------------------------------------------------
// falling_sand_grid_engine_core
// Falling-sand cellular automaton over a cell RAM: place, sweep and read.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries opcode_i, col_i, row_i.
//   Output channel (out_valid_o / out_stall_i) returns one result per item:
//   accepted_o, occupied_o, grain_color_o. A transfer happens when valid is
//   high and stall is low.
//   Config writes (cfg_valid_i / cfg_ready_o) go to change_after (index 0)
//   and palette_size (index 1); other indexes are dropped.
//   One item is processed at a time. Place and read check one RAM read
//   before the result; an unused opcode goes straight to the result. A
//   sweep visits every cell above the bottom row, column by column, upward
//   from the row above the floor; a grain tries below, then down-right,
//   then down-left, moves to the first free cell and clears its source.
//   The result sits in an output register, so a new item is taken while a
//   result waits; a second result waits in the sequencer until it drains.
//   After reset the RAM is cleared, one entry per cycle, through all
//   2^(clog2(GRID_W)+clog2(GRID_H)) entries (4096 at 64x64); in_stall_o is
//   high during that pass while config writes are still taken.
// ----------------------------------------------------------------------------
module falling_sand_grid_engine_core #(
  parameter int unsigned GRID_W = fsg_pkg::GRID_W_DEF,
  parameter int unsigned GRID_H = fsg_pkg::GRID_H_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     opcode_i,
  input  logic [5:0]                     col_i,
  input  logic [5:0]                     row_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           accepted_o,
  output logic                           occupied_o,
  output logic [2:0]                     grain_color_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fsg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fsg_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(GRID_W) + $clog2(GRID_H);

  logic          busy, commit, res_valid, res_ready;
  logic [2:0]    color;
  fsg_pkg::res_t res, out_q;
  logic          out_valid_q;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [3:0]    ram_wdata, ram_rdata;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy;

  fsg_palette u_palette (
    .clk_i,
    .rst_ni,
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .commit_i    (commit),
    .color_o     (color)
  );

  fsg_ctrl #(
    .GRID_W (GRID_W),
    .GRID_H (GRID_H)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .in_accept_i (in_valid_i && !busy),
    .opcode_i,
    .col_i,
    .row_i,
    .busy_o      (busy),
    .color_i     (color),
    .commit_o    (commit),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  fsg_ram #(
    .WIDTH (4),
    .DEPTH (2 ** AW)
  ) u_cells (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // output register
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign accepted_o    = out_q.accepted;
  assign occupied_o    = out_q.occupied;
  assign grain_color_o = out_q.grain_color;

endmodule

FILE: design/fsg_checker.sv
// ----------------------------------------------------------------------------
// fsg_checker
// Port-level checks for the falling-sand grid engine, bound to the top level.
// ----------------------------------------------------------------------------
module fsg_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       accepted_o,
  input logic       occupied_o,
  input logic [2:0] grain_color_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(accepted_o) && $stable(occupied_o)
      && $stable(grain_color_o))
    else $error("stalled result changed");

  // one item at a time: the sequencer is busy right after a transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in flight");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(accepted_o && occupied_o))
    else $error("place and read flags both set");

  a_color_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !occupied_o |-> grain_color_o == 3'd0)
    else $error("color reported for empty cell");

endmodule

bind falling_sand_grid_engine_core fsg_checker u_fsg_checker (
  .clk_i,
  .rst_ni,
  .in_valid_i,
  .in_stall_o,
  .out_valid_o,
  .out_stall_i,
  .accepted_o,
  .occupied_o,
  .grain_color_o
);

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for falling_sand_grid_engine_core: places, reads and
// gravity sweeps run against a cycle-free grid model, with random bursts on
// the input side and a random stall pattern on the result side.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned GW          = fsg_pkg::GRID_W_DEF;
  localparam int unsigned GH          = fsg_pkg::GRID_H_DEF;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic [1:0] opcode_i    = fsg_pkg::OP_NOP;
  logic [5:0] col_i       = '0;
  logic [5:0] row_i       = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       accepted_o;
  logic       occupied_o;
  logic [2:0] grain_color_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [fsg_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [fsg_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;

  // grid model state
  fsg_pkg::cell_t grid_m [GW][GH];
  logic [7:0]     place_cnt;
  logic [2:0]     cur_color;
  logic [7:0]     change_after_m;
  logic [3:0]     palette_m;

  fsg_pkg::res_t expected_res_q [$];
  int            err_cnt    = 0;
  int            burst_left = 0;
  int            stall_mode = 0;
  int unsigned   cycle_cnt  = 0;

  falling_sand_grid_engine_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .col_i         (col_i),
    .row_i         (row_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .accepted_o    (accepted_o),
    .occupied_o    (occupied_o),
    .grain_color_o (grain_color_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[falling_sand_grid_engine_core] ERROR");
      $finish;
    end
  end

  // Applies one item to the grid model and returns the result it must give.
  function automatic fsg_pkg::res_t grain_model(input fsg_pkg::opcode_e op,
                                                input logic [5:0] c,
                                                input logic [5:0] r);
    fsg_pkg::res_t res;
    int   p;
    int   x;
    int   y;
    res = '0;
    case (op)
      fsg_pkg::OP_PLACE: begin
        if (!grid_m[c][r].occ) begin
          grid_m[c][r].occ   = 1'b1;
          grid_m[c][r].color = cur_color;
          place_cnt = place_cnt + 8'd1;
          if (place_cnt >= change_after_m) begin
            p = int'(palette_m);
            if (p == 0) p = 1;
            if (p > 8) p = 8;
            place_cnt = '0;
            cur_color = 3'((int'(cur_color) + 1) % p);
          end
          res.accepted = 1'b1;
        end
      end
      fsg_pkg::OP_STEP: begin
        // in-place sweep: a grain pushed right may move again in its new column
        for (x = 0; x < GW; x++) begin
          for (y = GH - 2; y >= 0; y--) begin
            if (grid_m[x][y].occ) begin
              if (!grid_m[x][y+1].occ) begin
                grid_m[x][y+1] = grid_m[x][y];
                grid_m[x][y]   = '0;
              end else if (x + 1 < GW && !grid_m[x+1][y+1].occ) begin
                grid_m[x+1][y+1] = grid_m[x][y];
                grid_m[x][y]     = '0;
              end else if (x > 0 && !grid_m[x-1][y+1].occ) begin
                grid_m[x-1][y+1] = grid_m[x][y];
                grid_m[x][y]     = '0;
              end
            end
          end
        end
      end
      fsg_pkg::OP_READ: begin
        if (grid_m[c][r].occ) begin
          res.occupied    = 1'b1;
          res.grain_color = grid_m[c][r].color;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // result side: stall mode is redrawn at random from three modes, mode 0 never stalls
  always @(posedge clk_i) begin
    fsg_pkg::res_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_res_q.size() == 0) begin
        $error("unexpected result: accepted %0d occupied %0d grain_color %0d",
               accepted_o, occupied_o, grain_color_o);
        err_cnt++;
      end else begin
        exp_res = expected_res_q.pop_front();
        if (accepted_o !== exp_res.accepted) begin
          $error("accepted: expected %0d, got %0d", exp_res.accepted, accepted_o);
          err_cnt++;
        end
        if (occupied_o !== exp_res.occupied) begin
          $error("occupied: expected %0d, got %0d", exp_res.occupied, occupied_o);
          err_cnt++;
        end
        if (grain_color_o !== exp_res.grain_color) begin
          $error("grain_color: expected %0d, got %0d",
                 exp_res.grain_color, grain_color_o);
          err_cnt++;
        end
      end
    end
    if (cycle_cnt % 50 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Sends one item; valid stays high into the next call unless a gap is due.
  task automatic put_item(input fsg_pkg::opcode_e op, input logic [5:0] c,
                          input logic [5:0] r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    col_i      <= c;
    row_i      <= r;
    do @(posedge clk_i); while (in_stall_o);
    expected_res_q.push_back(grain_model(op, c, r));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_res_q.size() != 0) @(posedge clk_i);
  endtask

  // Writes both registers, optionally followed by two out-of-range indexes.
  task automatic write_regs(input logic [7:0] ca, input logic [7:0] pal,
                            input bit bad_idx);
    logic [fsg_pkg::CFG_IDX_W-1:0]  idx_l [4];
    logic [fsg_pkg::CFG_DATA_W-1:0] dat_l [4];
    int n;
    idx_l = '{fsg_pkg::REG_CHANGE_AFTER, fsg_pkg::REG_PALETTE_SIZE, 8'd2, 8'hFF};
    dat_l = '{ca, pal, 8'h55, 8'hAA};
    n = bad_idx ? 4 : 2;
    for (int i = 0; i < n; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx_l[i];
      cfg_data_i  <= dat_l[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      if (idx_l[i] == fsg_pkg::REG_CHANGE_AFTER) change_after_m = dat_l[i];
      else if (idx_l[i] == fsg_pkg::REG_PALETTE_SIZE) palette_m = dat_l[i][3:0];
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_place_read();
    put_item(fsg_pkg::OP_PLACE, 6'd0, 6'd0);
    put_item(fsg_pkg::OP_PLACE, 6'd0, 6'd0);     // already occupied
    put_item(fsg_pkg::OP_PLACE, 6'd63, 6'd63);
    put_item(fsg_pkg::OP_PLACE, 6'd42, 6'd21);
    put_item(fsg_pkg::OP_READ, 6'd0, 6'd0);
    put_item(fsg_pkg::OP_READ, 6'd63, 6'd63);
    put_item(fsg_pkg::OP_READ, 6'd21, 6'd42);    // empty
    put_item(fsg_pkg::OP_NOP, 6'd63, 6'd63);
  endtask

  task automatic test_gravity();
    put_item(fsg_pkg::OP_PLACE, 6'd63, 6'd62);   // right edge: only down-left is open
    put_item(fsg_pkg::OP_PLACE, 6'd5, 6'd63);
    put_item(fsg_pkg::OP_PLACE, 6'd6, 6'd63);
    put_item(fsg_pkg::OP_PLACE, 6'd5, 6'd62);    // blocked below and down-right
    put_item(fsg_pkg::OP_PLACE, 6'd10, 6'd63);
    put_item(fsg_pkg::OP_PLACE, 6'd10, 6'd62);   // slides down-right
    put_item(fsg_pkg::OP_STEP, 6'd0, 6'd0);
    put_item(fsg_pkg::OP_READ, 6'd62, 6'd63);
    put_item(fsg_pkg::OP_READ, 6'd4, 6'd63);
    put_item(fsg_pkg::OP_READ, 6'd11, 6'd63);
    put_item(fsg_pkg::OP_READ, 6'd0, 6'd1);
  endtask

  task automatic test_color_cycle();
    wait_idle();
    write_regs(8'd1, 8'd3, 1'b0);
    put_item(fsg_pkg::OP_PLACE, 6'd30, 6'd10);
    put_item(fsg_pkg::OP_PLACE, 6'd31, 6'd10);
    put_item(fsg_pkg::OP_PLACE, 6'd32, 6'd10);
    put_item(fsg_pkg::OP_READ, 6'd31, 6'd10);
    put_item(fsg_pkg::OP_READ, 6'd32, 6'd10);
    wait_idle();
    // zero threshold advances every time; zero palette acts as one color
    write_regs(8'd0, 8'hF0, 1'b0);
    put_item(fsg_pkg::OP_PLACE, 6'd33, 6'd10);
    put_item(fsg_pkg::OP_READ, 6'd33, 6'd10);
    wait_idle();
    write_regs(8'd255, 8'hFC, 1'b1);
  endtask

  task automatic test_random();
    logic [7:0]       ca;
    logic [7:0]       pal;
    logic [5:0]       c;
    logic [5:0]       r;
    int               hot_col;
    int               sel;
    bit               hot;
    fsg_pkg::opcode_e op;
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      case (ph)
        0:       begin ca = 8'd1;   pal = 8'h08; end
        1:       begin ca = 8'd255; pal = 8'h01; end
        2:       begin ca = 8'($urandom_range(2, 5)); pal = 8'($urandom_range(0, 15)); end
        default: begin ca = 8'($urandom_range(1, 255)); pal = 8'($urandom_range(0, 255)); end
      endcase
      write_regs(ca, pal, 1'b0);
      hot_col = $urandom_range(0, 7) * 8;
      repeat (19) begin
        // most items land in a narrow window near the floor so piles form
        sel = $urandom_range(0, 99);
        hot = ($urandom_range(0, 9) < 6);
        c = hot ? 6'(hot_col + $urandom_range(0, 7)) : 6'($urandom_range(0, 63));
        r = hot ? 6'($urandom_range(40, 63)) : 6'($urandom_range(0, 63));
        if (sel < 50)      op = fsg_pkg::OP_PLACE;
        else if (sel < 80) op = fsg_pkg::OP_READ;
        else if (sel < 92) op = fsg_pkg::OP_STEP;
        else               op = fsg_pkg::OP_NOP;
        put_item(op, c, r);
      end
    end
  endtask

  initial begin
    for (int x = 0; x < GW; x++)
      for (int y = 0; y < GH; y++)
        grid_m[x][y] = '0;
    place_cnt      = '0;
    cur_color      = '0;
    change_after_m = fsg_pkg::CHANGE_AFTER_RST;
    palette_m      = fsg_pkg::PALETTE_SIZE_RST;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_place_read();
    test_gravity();
    test_color_cycle();
    test_random();
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("[falling_sand_grid_engine_core] OK");
    end else begin
      $display("[falling_sand_grid_engine_core] ERROR");
    end
    $finish;
  end

endmodule
